FILE: rtl/lprf_pkg.sv
`default_nettype none

package lprf_pkg;

    // Field widths of a point and of the range result.
    localparam int COORD_BITS     = 20;
    localparam int INTENSITY_BITS = 16;

    // Sum of three squares and the square-root remainder.
    localparam int SUM_BITS = 2 * COORD_BITS;
    localparam int REM_BITS = COORD_BITS + 2;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_MIN_RANGE  = 2'd0,
        CFG_MAX_RANGE  = 2'd1,
        CFG_MIN_HEIGHT = 2'd2,
        CFG_MAX_HEIGHT = 2'd3
    } cfg_idx_t;

    // One input point.
    typedef struct packed {
        logic signed [COORD_BITS-1:0]   x_mm;
        logic signed [COORD_BITS-1:0]   y_mm;
        logic signed [COORD_BITS-1:0]   z_mm;
        logic        [INTENSITY_BITS-1:0] intensity;
        logic                           invalid;
        logic                           frame_last;
    } in_t;

    // One filtered result.
    typedef struct packed {
        logic                           keep;
        logic signed [COORD_BITS-1:0]   out_x_mm;
        logic signed [COORD_BITS-1:0]   out_y_mm;
        logic signed [COORD_BITS-1:0]   out_z_mm;
        logic        [INTENSITY_BITS-1:0] out_intensity;
        logic        [COORD_BITS-1:0]   range_mm;
        logic                           out_frame_last;
    } out_t;

    // Working state of the digit-by-digit square root.
    typedef struct packed {
        logic [REM_BITS-1:0]   rem;
        logic [COORD_BITS-1:0] root;
        logic [SUM_BITS-1:0]   rad;
    } sq_t;

    // Control that travels with every square-root step.
    typedef struct packed {
        logic enable;
        logic valid;
    } stg_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/lprf_sqrt_stage.sv
`default_nettype none

module lprf_sqrt_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lprf_pkg::stg_ctl_t in_ctl,
    input  wire lprf_pkg::sq_t    in_sq,
    input  wire lprf_pkg::in_t    in_pt,
    output logic                  out_valid,
    output lprf_pkg::sq_t         out_sq,
    output lprf_pkg::in_t         out_pt
);

    localparam int CB = lprf_pkg::COORD_BITS;
    localparam int RB = lprf_pkg::REM_BITS;
    localparam int SB = lprf_pkg::SUM_BITS;

    logic          valid_reg;
    lprf_pkg::sq_t sq_reg;
    lprf_pkg::sq_t sq_next;
    lprf_pkg::in_t pt_reg;

    logic [RB-1:0] rem_sh;
    logic [RB-1:0] trial;
    logic          fits;

    // One result bit: bring down the next two radicand bits and try to subtract.
    always_comb begin
        rem_sh = {in_sq.rem[RB-3:0], in_sq.rad[SB-1 -: 2]};
        trial  = {in_sq.root, 2'b01};
        fits   = (rem_sh >= trial);
        sq_next.rad = {in_sq.rad[SB-3:0], 2'b00};
        if (fits) begin
            sq_next.rem  = rem_sh - trial;
            sq_next.root = {in_sq.root[CB-2:0], 1'b1};
        end else begin
            sq_next.rem  = rem_sh;
            sq_next.root = {in_sq.root[CB-2:0], 1'b0};
        end
    end

    // The valid bit is reset; the data registers simply follow it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ctl.enable) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ctl.enable) begin
            sq_reg <= sq_next;
            pt_reg <= in_pt;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_pt    = pt_reg;

endmodule

`default_nettype wire

FILE: rtl/lidar_point_range_filter.sv
// Throughput: one point per cycle while the output is not stalled; the pipeline is one square stage,
// one sum stage, one stage per range bit of the square root and one compare and output stage.
// A stall at the output holds every stage at once, so no beat is lost or repeated.
// Reset is synchronous and active low: it clears all valid bits and loads the
// range and height bounds with their widest settings.
`default_nettype none

module lidar_point_range_filter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lprf_pkg::in_t     s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lprf_pkg::out_t         m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire lprf_pkg::cfg_idx_t cfg_index,
    input  wire logic [lprf_pkg::COORD_BITS-1:0] cfg_data
);

    localparam int CB = lprf_pkg::COORD_BITS;
    localparam int SB = lprf_pkg::SUM_BITS;

    // Configuration registers.
    logic        [CB-1:0] min_range_reg;
    logic        [CB-1:0] max_range_reg;
    logic signed [CB-1:0] min_height_reg;
    logic signed [CB-1:0] max_height_reg;

    // Whole pipeline moves together whenever the output register can take a beat.
    logic advance;

    // Square stage.
    logic          sqr_valid_reg;
    lprf_pkg::in_t sqr_pt_reg;
    logic [SB-1:0] sq_x_reg;
    logic [SB-1:0] sq_y_reg;
    logic [SB-1:0] sq_z_reg;
    logic [CB-1:0] mag_x;
    logic [CB-1:0] mag_y;
    logic [CB-1:0] mag_z;

    // Sum stage.
    logic          sum_valid_reg;
    lprf_pkg::in_t sum_pt_reg;
    logic [SB-1:0] sum_reg;
    logic [SB-1:0] sum_next;

    // Square-root chain: entry 0 is the sum stage, entry CB is the last step.
    logic               chain_valid [CB+1];
    lprf_pkg::sq_t      chain_sq    [CB+1];
    lprf_pkg::in_t      chain_pt    [CB+1];
    lprf_pkg::stg_ctl_t chain_ctl   [CB];

    // Output stage.
    logic           out_valid_reg;
    lprf_pkg::out_t out_reg;
    lprf_pkg::out_t out_next;
    lprf_pkg::in_t  fin_pt;
    logic [CB-1:0]  fin_range;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg  <= '0;
            max_range_reg  <= '1;
            min_height_reg <= {1'b1, {(CB-1){1'b0}}};
            max_height_reg <= {1'b0, {(CB-1){1'b1}}};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lprf_pkg::CFG_MIN_RANGE:  min_range_reg  <= cfg_data;
                lprf_pkg::CFG_MAX_RANGE:  max_range_reg  <= cfg_data;
                lprf_pkg::CFG_MIN_HEIGHT: min_height_reg <= cfg_data;
                lprf_pkg::CFG_MAX_HEIGHT: max_height_reg <= cfg_data;
            endcase
        end
    end

    // Magnitudes of the coordinates; the most negative value wraps to its true magnitude.
    assign mag_x = s_data.x_mm[CB-1] ? (~s_data.x_mm + CB'(1)) : s_data.x_mm;
    assign mag_y = s_data.y_mm[CB-1] ? (~s_data.y_mm + CB'(1)) : s_data.y_mm;
    assign mag_z = s_data.z_mm[CB-1] ? (~s_data.z_mm + CB'(1)) : s_data.z_mm;

    // Valid bits of the square, sum and output stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqr_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            sqr_valid_reg <= s_valid;
            sum_valid_reg <= sqr_valid_reg;
            out_valid_reg <= chain_valid[CB];
        end
    end

    // Squares of the magnitudes, one multiplier per coordinate.
    always_ff @(posedge aclk) begin
        if (advance) begin
            sqr_pt_reg <= s_data;
            sq_x_reg   <= SB'(mag_x) * SB'(mag_x);
            sq_y_reg   <= SB'(mag_y) * SB'(mag_y);
            sq_z_reg   <= SB'(mag_z) * SB'(mag_z);
        end
    end

    // Sum of squares; three squares of at most 2^(2*CB-2) stay below 2^SB.
    assign sum_next = sq_x_reg + sq_y_reg + sq_z_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            sum_pt_reg <= sqr_pt_reg;
            sum_reg    <= sum_next;
        end
    end

    // Seed of the square-root chain.
    assign chain_valid[0]   = sum_valid_reg;
    assign chain_pt[0]      = sum_pt_reg;
    assign chain_sq[0].rem  = '0;
    assign chain_sq[0].root = '0;
    assign chain_sq[0].rad  = sum_reg;

    // One registered step per result bit.
    for (genvar k = 0; k < CB; k++) begin : g_sqrt
        assign chain_ctl[k].enable = advance;
        assign chain_ctl[k].valid  = chain_valid[k];

        lprf_sqrt_stage u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctl    (chain_ctl[k]),
            .in_sq     (chain_sq[k]),
            .in_pt     (chain_pt[k]),
            .out_valid (chain_valid[k+1]),
            .out_sq    (chain_sq[k+1]),
            .out_pt    (chain_pt[k+1])
        );
    end

    // Range and height checks; all bounds are inclusive.
    assign fin_pt    = chain_pt[CB];
    assign fin_range = chain_sq[CB].root;

    always_comb begin
        out_next.keep = !fin_pt.invalid
            && (fin_range >= min_range_reg) && (fin_range <= max_range_reg)
            && ($signed(fin_pt.z_mm) >= min_height_reg)
            && ($signed(fin_pt.z_mm) <= max_height_reg);
        out_next.out_x_mm       = fin_pt.x_mm;
        out_next.out_y_mm       = fin_pt.y_mm;
        out_next.out_z_mm       = fin_pt.z_mm;
        out_next.out_intensity  = fin_pt.intensity;
        out_next.range_mm       = fin_range;
        out_next.out_frame_last = fin_pt.frame_last;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
